FILE: hw/rtl/prip_pkg.sv
package prip_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_ALIGN  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_UPLOAD = 2'd3
  } op_t;

  // Register index as decoded from paddr[2].
  typedef enum logic {
    REG_ON_LEVEL   = 1'b0,
    REG_IDLE_LEVEL = 1'b1
  } reg_idx_t;

  localparam int CFG_ADDR_W = 3;

  localparam int ITEM_W    = 16;
  localparam int DUR_W     = 15;
  localparam int LEVEL_BIT = 15;
  localparam logic [DUR_W-1:0] DUR_MAX = 15'h7fff;

endpackage

FILE: hw/rtl/prip_cmd_if.sv
interface prip_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic        on_flag;
  logic [15:0] run_cycles;
  logic [15:0] reference_total;

  modport source (
    output valid, operation, on_flag, run_cycles, reference_total,
    input  ready
  );
  modport sink (
    input  valid, operation, on_flag, run_cycles, reference_total,
    output ready
  );
endinterface

FILE: hw/rtl/prip_rsp_if.sv
interface prip_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_word;
  logic        last;
  logic [6:0]  item_count;
  logic [31:0] total_ticks;
  logic        overflow;

  modport source (
    output valid, packed_word, last, item_count, total_ticks, overflow,
    input  ready
  );
  modport sink (
    input  valid, packed_word, last, item_count, total_ticks, overflow,
    output ready
  );
endinterface

FILE: hw/rtl/prip_ram.sv
module prip_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 126
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/pulse_run_item_packer.sv
// Pulse run item packer.
// Commands arrive as beats on cmd (valid/ready); each one gives one or more
// beats on rsp. Append and align add a run to the item store, merging it into
// the last item when the level matches, clear empties the store, and upload
// streams the store as 32-bit words of two items and ends in a terminator
// word, which also holds an odd last item and alone carries last. Every
// other command gives a single beat. The levels are set over the APB port:
// on_level at 0x0, idle_level at 0x4. cmd is taken only while the sequencer
// is idle. A zero-length append or align goes straight to the done state;
// any other passes through the merge state when the store already holds
// items, then the fill state, where the shared min/subtract unit works one
// item per cycle, and then the done state. An upload reads each item in turn
// through the item store's single read port, which has registered output.
// rsp is held in an output register, so the next command is accepted while
// a beat waits; a stalled receiver stops the sequencer only when it has a
// further beat to hand over. Reset empties the store, zeroes the tick total
// and sets on_level to 1 and idle_level to 0; no clearing pass is needed.
module pulse_run_item_packer
  import prip_pkg::*;
#(
  parameter int ITEM_CAPACITY = 126
) (
  input  logic                  clk,
  input  logic                  rst,
  prip_cmd_if.sink              cmd,
  prip_rsp_if.source            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int AW = $clog2(ITEM_CAPACITY);
  localparam int CW = $clog2(ITEM_CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(ITEM_CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_MERGE    = 6'b000010,
    S_FILL     = 6'b000100,
    S_DONE     = 6'b001000,
    S_UP_ISSUE = 6'b010000,
    S_UP_CAP   = 6'b100000
  } state_t;

  state_t state;
  logic              on_level;
  logic              idle_level;
  logic [CW-1:0]     count;
  logic [31:0]       total;
  logic              lost;
  logic [CW-1:0]     ptr;
  logic              half;
  logic              level;
  logic [15:0]       len;
  logic [ITEM_W-1:0] lo;
  logic              out_valid;

  logic              accept;
  logic              level_in;
  logic [15:0]       len_in;
  logic [CW-1:0]     cnt_dec;
  logic [DUR_W-1:0]  room;
  logic [15:0]       lim;
  logic [15:0]       take;
  logic [15:0]       len_rest;
  logic              match;
  logic              slot_free;
  logic              emit;
  logic [31:0]       emit_word;
  logic              emit_last;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ITEM_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [ITEM_W-1:0] ram_rdata;

  prip_ram #(
    .WIDTH(ITEM_W),
    .DEPTH(ITEM_CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign pready = 1'b1;
  assign prdata = {31'b0, (paddr[2] == REG_IDLE_LEVEL) ? idle_level : on_level};

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign level_in  = cmd.on_flag ? on_level : ~on_level;
  assign len_in    = (cmd.operation == OP_ALIGN) ? (cmd.reference_total - total[15:0])
                                                 : cmd.run_cycles;
  assign cnt_dec   = count - CW'(1);
  assign slot_free = !out_valid || rsp.ready;

  // Shared unit: take the smaller of the remaining length and the room left,
  // either in the last stored item or in a fresh one.
  always_comb begin
    room     = DUR_MAX - ram_rdata[DUR_W-1:0];
    lim      = (state == S_MERGE) ? {1'b0, room} : {1'b0, DUR_MAX};
    take     = (len < lim) ? len : lim;
    len_rest = len - take;
    match    = (ram_rdata[LEVEL_BIT] == level);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = {level, take[DUR_W-1:0]};
    ram_re    = 1'b0;
    ram_raddr = ptr[AW-1:0];
    case (state)
      S_IDLE: begin
        // Fetch the last item in case the next command merges into it.
        ram_re    = 1'b1;
        ram_raddr = cnt_dec[AW-1:0];
      end
      S_MERGE: begin
        ram_we    = match;
        ram_waddr = cnt_dec[AW-1:0];
        ram_wdata = {level, ram_rdata[DUR_W-1:0] + take[DUR_W-1:0]};
      end
      S_FILL: begin
        ram_we = (len != 16'd0) && (count < CAP_CNT);
      end
      S_UP_ISSUE: begin
        ram_re = (ptr != count);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    emit_word = 32'd0;
    emit_last = 1'b1;
    case (state)
      S_DONE: begin
        emit = slot_free;
      end
      S_UP_ISSUE: begin
        if (ptr == count) begin
          emit      = slot_free;
          emit_word = {16'd0, idle_level, 15'd0};
        end
      end
      S_UP_CAP: begin
        if (!half) begin
          if (ptr == count) begin
            // Odd count: the last item shares the word with the terminator.
            emit      = slot_free;
            emit_word = {idle_level, 15'd0, ram_rdata};
          end
        end else begin
          emit      = slot_free;
          emit_word = {ram_rdata, lo};
          emit_last = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      on_level   <= 1'b1;
      idle_level <= 1'b0;
      count      <= '0;
      total      <= 32'd0;
      lost       <= 1'b0;
      ptr        <= '0;
      half       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_IDLE_LEVEL) begin
          idle_level <= pwdata[0];
        end else begin
          on_level <= pwdata[0];
        end
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            lost <= 1'b0;
            case (cmd.operation)
              OP_APPEND, OP_ALIGN: begin
                if (len_in == 16'd0) begin
                  state <= S_DONE;
                end else begin
                  total <= total + {16'd0, len_in};
                  state <= (count != '0) ? S_MERGE : S_FILL;
                end
              end
              OP_CLEAR: begin
                count <= '0;
                total <= 32'd0;
                state <= S_DONE;
              end
              default: begin
                ptr   <= '0;
                half  <= 1'b0;
                state <= S_UP_ISSUE;
              end
            endcase
          end
        end
        S_MERGE: begin
          state <= S_FILL;
        end
        S_FILL: begin
          if (len == 16'd0) begin
            state <= S_DONE;
          end else if (count >= CAP_CNT) begin
            lost  <= 1'b1;
            state <= S_DONE;
          end else begin
            count <= count + CW'(1);
          end
        end
        S_DONE: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        S_UP_ISSUE: begin
          if (ptr == count) begin
            if (emit) begin
              state <= S_IDLE;
            end
          end else begin
            ptr   <= ptr + CW'(1);
            state <= S_UP_CAP;
          end
        end
        S_UP_CAP: begin
          if (!half) begin
            if (ptr == count) begin
              if (emit) begin
                state <= S_IDLE;
              end
            end else begin
              half  <= 1'b1;
              state <= S_UP_ISSUE;
            end
          end else if (emit) begin
            half  <= 1'b0;
            state <= S_UP_ISSUE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      level <= level_in;
      len   <= len_in;
    end else if ((state == S_MERGE && match) || state == S_FILL) begin
      len <= len_rest;
    end
    if (state == S_UP_CAP && !half) begin
      lo <= ram_rdata;
    end
    if (emit) begin
      rsp.packed_word <= emit_word;
      rsp.last        <= emit_last;
      rsp.item_count  <= 7'(count);
      rsp.total_ticks <= total;
      rsp.overflow    <= (state == S_DONE) ? lost : 1'b0;
    end
  end

  assign rsp.valid = out_valid;

endmodule

FILE: sim/tb_pulse_run_item_packer.sv
module tb_pulse_run_item_packer;
  import prip_pkg::*;

  localparam int ITEM_CAPACITY = 126;
  localparam int TAIL_CYCLES   = 20;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_ITEMS  = 450;

  typedef struct {
    op_t         op;
    logic        on_flag;
    logic [15:0] run_cycles;
    logic [15:0] reference_total;
  } pulse_cmd_t;

  typedef struct {
    logic [31:0] packed_word;
    logic        last;
    logic [6:0]  item_count;
    logic [31:0] total_ticks;
    logic        overflow;
  } word_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  prip_cmd_if cmd_ch ();
  prip_rsp_if rsp_ch ();

  pulse_run_item_packer #(
    .ITEM_CAPACITY(ITEM_CAPACITY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Commands waiting to be driven, and the word beats the packer owes us.
  pulse_cmd_t cmd_queue[$];
  word_beat_t owed_beats[$];

  // Shadow of the packer's state, updated as each command is accepted.
  logic [15:0] shadow_items [ITEM_CAPACITY];
  int          shadow_count;
  logic [31:0] shadow_ticks;
  logic        cfg_on_level;
  logic        cfg_idle_level;

  // Tick total as seen when commands are queued, so that aligns can aim at it.
  logic [31:0] gen_total;

  int  error_count;
  int  beats_checked;
  int  overflow_beats;
  int  max_count_seen;
  int  cmds_by_op [4];
  int  queued_items;
  int  accepted_items;
  bit  cmd_fire;
  bit  gaps_enabled;
  int  cmd_gap;
  int  rsp_gap;
  int  hold_left;
  int  hold_requests;
  int  hold_served;

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= 30) begin
      $display("mismatch: %s after %0d beats, expected %h, got %h", what, beats_checked,
               want, got);
    end
  endtask

  // Adds a run at the given level, merging into the last item where the level
  // matches and spilling the rest into items of at most DUR_MAX ticks.
  function automatic bit add_run(logic lvl, int unsigned len);
    int unsigned dur;
    int unsigned room;
    int unsigned take;
    bit          lost;
    lost = 1'b0;
    if (len != 0) begin
      shadow_ticks += len;
      if (shadow_count > 0 && shadow_items[shadow_count-1][LEVEL_BIT] == lvl) begin
        dur  = shadow_items[shadow_count-1][DUR_W-1:0];
        room = DUR_MAX - dur;
        take = (len < room) ? len : room;
        shadow_items[shadow_count-1] = {lvl, DUR_W'(dur + take)};
        len -= take;
      end
      while (len > 0 && !lost) begin
        take = (len < DUR_MAX) ? len : DUR_MAX;
        if (shadow_count >= ITEM_CAPACITY) begin
          lost = 1'b1;
        end else begin
          shadow_items[shadow_count] = {lvl, DUR_W'(take)};
          shadow_count++;
          len -= take;
        end
      end
    end
    return lost;
  endfunction

  function automatic void owe_beat(logic [31:0] word, logic last, logic ovf);
    word_beat_t b;
    b.packed_word = word;
    b.last        = last;
    b.item_count  = 7'(shadow_count);
    b.total_ticks = shadow_ticks;
    b.overflow    = ovf;
    owed_beats.push_back(b);
  endfunction

  function automatic void predict_beats(pulse_cmd_t c);
    logic        lvl;
    logic [15:0] diff;
    bit          lost;
    int          w;
    lvl  = c.on_flag ? cfg_on_level : ~cfg_on_level;
    lost = 1'b0;
    if (c.op == OP_UPLOAD) begin
      for (w = 0; w < shadow_count / 2; w++) begin
        owe_beat({shadow_items[2*w+1], shadow_items[2*w]}, 1'b0, 1'b0);
      end
      // An odd count leaves the last item to share the word with the terminator.
      if (shadow_count % 2 == 0) begin
        owe_beat({16'h0000, cfg_idle_level, 15'h0000}, 1'b1, 1'b0);
      end else begin
        owe_beat({cfg_idle_level, 15'h0000, shadow_items[shadow_count-1]}, 1'b1, 1'b0);
      end
    end else begin
      case (c.op)
        OP_APPEND: begin
          lost = add_run(lvl, c.run_cycles);
        end
        OP_ALIGN: begin
          diff = c.reference_total - shadow_ticks[15:0];
          lost = add_run(lvl, diff);
        end
        default: begin
          shadow_count = 0;
          shadow_ticks = '0;
        end
      endcase
      owe_beat(32'h0, 1'b1, lost);
    end
  endfunction

  always @(posedge clk) begin : monitor
    word_beat_t want;
    pulse_cmd_t c;
    if (rst) begin
      cmd_fire = 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_beats.size() == 0) begin
          report_mismatch("beat with nothing owed", 32'h0, rsp_ch.packed_word);
        end else begin
          want = owed_beats.pop_front();
          if (rsp_ch.packed_word !== want.packed_word)
            report_mismatch("packed_word", want.packed_word, rsp_ch.packed_word);
          if (rsp_ch.last !== want.last)
            report_mismatch("last", 32'(want.last), 32'(rsp_ch.last));
          if (rsp_ch.item_count !== want.item_count)
            report_mismatch("item_count", 32'(want.item_count), 32'(rsp_ch.item_count));
          if (rsp_ch.total_ticks !== want.total_ticks)
            report_mismatch("total_ticks", want.total_ticks, rsp_ch.total_ticks);
          if (rsp_ch.overflow !== want.overflow)
            report_mismatch("overflow", 32'(want.overflow), 32'(rsp_ch.overflow));
          if (want.overflow) overflow_beats++;
          if (int'(want.item_count) > max_count_seen) max_count_seen = want.item_count;
        end
        beats_checked++;
      end
      cmd_fire = cmd_ch.valid && cmd_ch.ready;
      if (cmd_fire) begin
        c.op              = op_t'(cmd_ch.operation);
        c.on_flag         = cmd_ch.on_flag;
        c.run_cycles      = cmd_ch.run_cycles;
        c.reference_total = cmd_ch.reference_total;
        cmds_by_op[c.op]++;
        accepted_items++;
        predict_beats(c);
      end
    end
  end

  always @(negedge clk) begin : cmd_driver
    pulse_cmd_t c;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_fire) begin
      if (cmd_gap > 0) begin
        cmd_gap--;
        cmd_ch.valid <= 1'b0;
      end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
        cmd_gap = $urandom_range(0, 14);
        cmd_ch.valid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        c = cmd_queue.pop_front();
        cmd_ch.valid           <= 1'b1;
        cmd_ch.operation       <= c.op;
        cmd_ch.on_flag         <= c.on_flag;
        cmd_ch.run_cycles      <= c.run_cycles;
        cmd_ch.reference_total <= c.reference_total;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : rsp_sink
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD - 1;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (rsp_gap > 0) begin
      rsp_gap--;
      rsp_ch.ready <= 1'b0;
    end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
      rsp_gap = $urandom_range(0, 14);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic check_config_reg(reg_idx_t idx, logic want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[0] !== want) report_mismatch("register read", 32'(want), prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_config_reg(reg_idx_t idx, logic val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= {31'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ON_LEVEL) cfg_on_level = val;
    else cfg_idle_level = val;
    check_config_reg(idx, val);
  endtask

  task automatic set_levels(logic on_lvl, logic idle_lvl);
    write_config_reg(REG_ON_LEVEL, on_lvl);
    write_config_reg(REG_IDLE_LEVEL, idle_lvl);
  endtask

  // Every queued command must have been taken and every owed beat delivered.
  task automatic wait_for_drain();
    while (accepted_items != queued_items || owed_beats.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  function automatic void queue_cmd(op_t op, logic on, logic [15:0] run,
                                    logic [15:0] ref_total);
    pulse_cmd_t  c;
    logic [15:0] diff;
    c.op              = op;
    c.on_flag         = on;
    c.run_cycles      = run;
    c.reference_total = ref_total;
    cmd_queue.push_back(c);
    queued_items++;
    case (op)
      OP_APPEND: gen_total += run;
      OP_ALIGN: begin
        diff = ref_total - gen_total[15:0];
        gen_total += diff;
      end
      OP_CLEAR: gen_total = '0;
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] random_run();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1, 2:    return 16'($urandom_range(1, 40));
      3:       return 16'($urandom_range(32760, 32775));
      4:       return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Align either hits the running total exactly, lands 1 to 40000 ticks past
  // it, or takes an arbitrary reference.
  function automatic logic [15:0] random_reference();
    case ($urandom_range(0, 3))
      0:       return gen_total[15:0];
      1:       return gen_total[15:0] + 16'($urandom_range(1, 40000));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void queue_build_and_upload();
    int n;
    int k;
    if ($urandom_range(0, 1) == 0) queue_cmd(OP_CLEAR, 1'($urandom), random_run(), 16'($urandom));
    n = $urandom_range(1, 10);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0)
        queue_cmd(OP_ALIGN, 1'($urandom), 16'($urandom), random_reference());
      else
        queue_cmd(OP_APPEND, 1'($urandom), random_run(), 16'($urandom));
    end
    queue_cmd(OP_UPLOAD, 1'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  // Long runs of mostly alternating level run the store up to capacity and
  // beyond, then three random appends or aligns try to merge at the full store.
  function automatic void queue_fill_to_overflow();
    int   k;
    logic on;
    queue_cmd(OP_CLEAR, 1'($urandom), 16'($urandom), 16'($urandom));
    on = 1'($urandom);
    for (k = 0; k < 50; k++) begin
      if ($urandom_range(0, 7) != 0) on = ~on;
      queue_cmd(OP_APPEND, on,
                $urandom_range(0, 1) ? 16'hffff : 16'($urandom_range(32768, 65535)),
                16'($urandom));
    end
    for (k = 0; k < 3; k++) begin
      if ($urandom_range(0, 1) == 0)
        queue_cmd(OP_APPEND, 1'($urandom), random_run(), 16'($urandom));
      else
        queue_cmd(OP_ALIGN, 1'($urandom), 16'($urandom), random_reference());
    end
    queue_cmd(OP_UPLOAD, 1'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  function automatic void queue_random_phase(int budget);
    int start;
    int k;
    start = queued_items;
    queue_fill_to_overflow();
    while (queued_items - start < budget) begin
      if ($urandom_range(0, 4) == 0) begin
        for (k = $urandom_range(1, 4); k > 0; k--)
          queue_cmd(op_t'($urandom_range(0, 3)), 1'($urandom), 16'($urandom),
                    16'($urandom));
      end else begin
        queue_build_and_upload();
      end
    end
  endfunction

  initial begin
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    cmd_ch.valid           = 1'b0;
    cmd_ch.operation       = OP_APPEND;
    cmd_ch.on_flag         = 1'b0;
    cmd_ch.run_cycles      = '0;
    cmd_ch.reference_total = '0;
    rsp_ch.ready           = 1'b0;
    shadow_count   = 0;
    shadow_ticks   = '0;
    cfg_on_level   = 1'b1;
    cfg_idle_level = 1'b0;
    gen_total      = '0;
    gaps_enabled   = 1'b1;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    check_config_reg(REG_ON_LEVEL, 1'b1);
    check_config_reg(REG_IDLE_LEVEL, 1'b0);

    // Directed part at the reset levels.
    queue_cmd(OP_UPLOAD, 1'b1, 16'h0000, 16'h0000);
    queue_cmd(OP_APPEND, 1'b1, 16'h0000, 16'h0000);
    queue_cmd(OP_APPEND, 1'b1, 16'hffff, 16'h0000);
    queue_cmd(OP_APPEND, 1'b1, 16'd5, 16'h0000);
    queue_cmd(OP_APPEND, 1'b0, 16'h8000, 16'h0000);
    queue_cmd(OP_UPLOAD, 1'b0, 16'h0000, 16'h0000);
    queue_cmd(OP_APPEND, 1'b0, 16'd40000, 16'h0000);
    queue_cmd(OP_UPLOAD, 1'b1, 16'hffff, 16'hffff);
    queue_cmd(OP_ALIGN, 1'b1, 16'h0000, gen_total[15:0]);
    queue_cmd(OP_ALIGN, 1'b0, 16'h0000, gen_total[15:0] - 16'd1);
    queue_cmd(OP_CLEAR, 1'b0, 16'hffff, 16'hffff);
    queue_cmd(OP_ALIGN, 1'b1, 16'hffff, 16'h0000);
    queue_cmd(OP_ALIGN, 1'b0, 16'h0000, 16'hffff);
    queue_cmd(OP_ALIGN, 1'b1, 16'h0000, 16'h0000);
    queue_cmd(OP_APPEND, 1'b1, 16'haaaa, 16'h5555);
    queue_cmd(OP_APPEND, 1'b0, 16'h5555, 16'haaaa);
    queue_cmd(OP_UPLOAD, 1'b1, 16'hffff, 16'hffff);
    queue_cmd(OP_CLEAR, 1'b1, 16'h0000, 16'h0000);
    queue_cmd(OP_UPLOAD, 1'b0, 16'h0000, 16'h0000);
    wait_for_drain();

    set_levels(1'b0, 1'b1);
    queue_random_phase(RANDOM_ITEMS / 4);
    wait_for_drain();

    // The receiver stalls for a long stretch while commands keep coming.
    set_levels(1'b1, 1'b1);
    queue_random_phase(RANDOM_ITEMS / 4);
    hold_requests++;
    wait_for_drain();

    set_levels(1'b0, 1'b0);
    queue_random_phase(RANDOM_ITEMS / 4);
    wait_for_drain();

    // Back-to-back traffic with no idling on either side.
    set_levels(1'b1, 1'b0);
    gaps_enabled = 1'b0;
    queue_random_phase(RANDOM_ITEMS / 4);
    wait_for_drain();

    if (owed_beats.size() != 0) report_mismatch("beats never delivered", 32'h0,
                                                32'(owed_beats.size()));
    $display("Ran %0d appends, %0d aligns, %0d clears and %0d uploads over four level settings.",
             cmds_by_op[OP_APPEND], cmds_by_op[OP_ALIGN], cmds_by_op[OP_CLEAR],
             cmds_by_op[OP_UPLOAD]);
    $display("Checked %0d word beats; %0d reported a lost run; the store peaked at %0d items.",
             beats_checked, overflow_beats, max_count_seen);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/prip_pkg.sv
hw/rtl/prip_cmd_if.sv
hw/rtl/prip_rsp_if.sv
hw/rtl/prip_ram.sv
hw/rtl/pulse_run_item_packer.sv
sim/tb_pulse_run_item_packer.sv
